/* rtl/rps_pkg.sv */
// ============================================================================
// rps_pkg
// Shared types, codes and constants for the length-prefixed string parser.
// ============================================================================
package rps_pkg;

    localparam longint unsigned MAX_TEXT_LEN = 64'd65535;
    localparam longint unsigned LEN_SAT      = 64'd65535;

    // Payload counter tops out where both the too-long flag and text_length
    // saturation are still exact.
    localparam longint unsigned CNT_TOP =
        (MAX_TEXT_LEN + 64'd1 > LEN_SAT) ? (MAX_TEXT_LEN + 64'd1) : LEN_SAT;
    localparam int CNT_W = $clog2(CNT_TOP + 64'd1);
    localparam int MAG_W = 32;
    localparam int LEN_W = 16;
    localparam int CMP_W = (CNT_W > MAG_W) ? CNT_W : MAG_W;

    localparam logic [MAG_W-1:0] LIMIT_MAG = 32'h8000_0000;
    localparam logic [MAG_W-1:0] INT_MAX   = 32'h7FFF_FFFF;

    // parse phase
    localparam logic [1:0] PH_TYPE = 2'd0;
    localparam logic [1:0] PH_HDR  = 2'd1;
    localparam logic [1:0] PH_BODY = 2'd2;

    // number reader stage
    localparam logic [1:0] NS_SKIP  = 2'd0;
    localparam logic [1:0] NS_SIGN  = 2'd1;
    localparam logic [1:0] NS_DIGIT = 2'd2;
    localparam logic [1:0] NS_DONE  = 2'd3;

    // message kind
    localparam logic [1:0] KIND_BULK = 2'd0;
    localparam logic [1:0] KIND_ERR  = 2'd1;
    localparam logic [1:0] KIND_VERB = 2'd2;

    // status codes
    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_NULL     = 3'd1;
    localparam logic [2:0] ST_ENC      = 3'd2;
    localparam logic [2:0] ST_MISMATCH = 3'd3;
    localparam logic [2:0] ST_NOTNUM   = 3'd4;
    localparam logic [2:0] ST_RANGE    = 3'd5;
    localparam logic [2:0] ST_LONG     = 3'd6;

    localparam logic [7:0] CH_CR     = 8'd13;
    localparam logic [7:0] CH_LF     = 8'd10;
    localparam logic [7:0] CH_TAB    = 8'd9;
    localparam logic [7:0] CH_SPACE  = 8'h20;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_MINUS  = 8'h2D;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_ONE    = 8'h31;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_COLON  = 8'h3A;
    localparam logic [7:0] CH_DOLLAR = 8'h24;

    localparam logic [2:0] POS_LAST   = 3'd7;
    localparam logic [2:0] NULL_LEN   = 3'd5;
    localparam logic [2:0] NULL_END   = 3'd4;
    localparam int unsigned COLON_OFS = 3;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
        logic [1:0] kind;
    } t_item;

    typedef struct packed {
        logic [7:0]       out_byte;
        logic             is_payload;
        logic [2:0]       status;
        logic [LEN_W-1:0] text_length;
    } t_result;

    // "$-1" CR LF
    function automatic logic [7:0] null_tmpl(input logic [2:0] pos);
        logic [7:0] ch;
        case (pos)
            3'd0:    ch = CH_DOLLAR;
            3'd1:    ch = CH_MINUS;
            3'd2:    ch = CH_ONE;
            3'd3:    ch = CH_CR;
            3'd4:    ch = CH_LF;
            default: ch = 8'd0;
        endcase
        return ch;
    endfunction

endpackage

/* rtl/rps_in_stage.sv */
// ============================================================================
// rps_in_stage
// Input register: holds one accepted byte beat until the parser takes it.
// ============================================================================
module rps_in_stage (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    input  logic [7:0]    i_data_byte,
    input  logic          i_last_byte,
    input  logic [1:0]    i_kind,
    output logic          o_stall,
    input  logic          i_take,
    output logic          o_item_valid,
    output rps_pkg::t_item o_item
);
    import rps_pkg::*;

    logic  r_valid;
    t_item r_item;
    logic  load;

    assign o_stall      = r_valid && !i_take;
    assign load         = i_valid && !o_stall;
    assign o_item_valid = r_valid;
    assign o_item       = r_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_item <= '{data_byte: i_data_byte, last_byte: i_last_byte, kind: i_kind};
        end
    end

endmodule

/* rtl/rps_parse.sv */
// ============================================================================
// rps_parse
// Message state and per-byte update: header number, framing, null and colon
// checks, payload counting, result formation.
// ============================================================================
module rps_parse (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_go,
    input  rps_pkg::t_item   i_item,
    output logic             o_res_valid,
    output rps_pkg::t_result o_res
);
    import rps_pkg::*;

    logic [1:0]       r_phase, n_phase;
    logic [1:0]       r_kind, n_kind;
    logic [2:0]       r_pos, n_pos;
    logic [1:0]       r_null, n_null;
    logic [7:0]       r_held_byte, n_held_byte;
    logic [1:0]       r_held_vc, n_held_vc;
    logic             r_frame_bad, n_frame_bad;
    logic [1:0]       r_nstage, n_nstage;
    logic             r_neg, n_neg;
    logic [MAG_W-1:0] r_mag, n_mag;
    logic [1:0]       r_nflags, n_nflags;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_long, n_long;
    logic [1:0]       r_colon, n_colon;

    logic [7:0]       b;
    logic             last;
    logic             is_digit, is_ws;
    logic [35:0]      prod;
    logic             ovf;
    logic [MAG_W-1:0] mag_dig;
    logic             emit, term, dash_one, match;
    logic [2:0]       st;
    logic [63:0]      cnt_wide;
    logic [LEN_W-1:0] len_out;

    assign b        = i_item.data_byte;
    assign last     = i_item.last_byte;
    assign is_digit = (b >= CH_ZERO) && (b <= CH_NINE);
    assign is_ws    = (b == CH_SPACE) || ((b >= CH_TAB) && (b <= CH_CR));
    assign prod     = 36'(r_mag) * 36'd10 + 36'(b[3:0]);
    assign ovf      = prod > 36'(LIMIT_MAG);
    assign mag_dig  = ovf ? LIMIT_MAG : prod[MAG_W-1:0];

    always_comb begin
        n_phase     = r_phase;
        n_kind      = r_kind;
        n_pos       = r_pos;
        n_null      = r_null;
        n_held_byte = r_held_byte;
        n_held_vc   = r_held_vc;
        n_frame_bad = r_frame_bad;
        n_nstage    = r_nstage;
        n_neg       = r_neg;
        n_mag       = r_mag;
        n_nflags    = r_nflags;
        n_cnt       = r_cnt;
        n_long      = r_long;
        n_colon     = r_colon;
        emit        = 1'b0;
        term        = 1'b0;

        if (r_phase == PH_TYPE) begin
            n_kind = i_item.kind;
        end

        if ((r_pos >= NULL_LEN) || (b != null_tmpl(r_pos))) begin
            n_null[1] = 1'b1;
        end
        if (r_pos == 3'd1) begin
            n_null[0] = (b == CH_MINUS);
        end
        if (r_pos == 3'd2) begin
            n_null[0] = r_null[0] && (b == CH_ONE);
        end
        if (r_pos != POS_LAST) begin
            n_pos = r_pos + 3'd1;
        end

        unique case (r_phase)
            PH_TYPE: begin
                n_held_vc = {b == CH_CR, 1'b0};
                n_phase   = PH_HDR;
            end
            PH_HDR: begin
                if (r_held_vc[1] && (b == CH_LF)) begin
                    if (r_pos == 3'd1) begin
                        n_frame_bad = 1'b1;
                    end
                    n_phase   = PH_BODY;
                    n_held_vc = 2'b00;
                end else begin
                    n_held_vc = {b == CH_CR, 1'b0};
                    case (r_nstage)
                        NS_SKIP: begin
                            if (is_ws) begin
                                n_nstage = NS_SKIP;
                            end else if ((b == CH_PLUS) || (b == CH_MINUS)) begin
                                n_neg    = (b == CH_MINUS);
                                n_nstage = NS_SIGN;
                            end else if (is_digit) begin
                                n_mag    = mag_dig;
                                n_nflags = {r_nflags[1] | ovf, 1'b1};
                                n_nstage = NS_DIGIT;
                            end else begin
                                n_nstage = NS_DONE;
                            end
                        end
                        NS_SIGN, NS_DIGIT: begin
                            if (is_digit) begin
                                n_mag    = mag_dig;
                                n_nflags = {r_nflags[1] | ovf, 1'b1};
                                n_nstage = NS_DIGIT;
                            end else begin
                                n_nstage = NS_DONE;
                            end
                        end
                        default: n_nstage = r_nstage;
                    endcase
                end
            end
            default: begin
                if (last) begin
                    term = r_held_vc[0] && r_held_vc[1] && (b == CH_LF);
                end else begin
                    if (r_held_vc[0]) begin
                        emit = 1'b1;
                        if ((r_held_byte == CH_COLON) && !r_colon[0]) begin
                            n_colon = {r_cnt != CNT_W'(COLON_OFS), 1'b1};
                        end
                        if (r_cnt != CNT_W'(CNT_TOP)) begin
                            n_cnt = r_cnt + CNT_W'(1);
                        end
                        if (64'(n_cnt) > MAX_TEXT_LEN) begin
                            n_long = 1'b1;
                        end
                        if (r_held_vc[1] && (b == CH_LF)) begin
                            n_frame_bad = 1'b1;
                        end
                    end
                    n_held_byte = b;
                    n_held_vc   = {b == CH_CR, 1'b1};
                end
            end
        endcase

        dash_one = n_null[0] && (r_pos >= 3'd2);
        match    = (CMP_W'(n_mag) == CMP_W'(n_cnt)) && (!n_neg || (n_mag == '0));
        if ((n_kind == KIND_BULK) && dash_one) begin
            st = (!n_null[1] && (r_pos == NULL_END)) ? ST_NULL : ST_ENC;
        end else if (n_frame_bad || !term) begin
            st = ST_ENC;
        end else if ((n_kind == KIND_VERB) && n_colon[1]) begin
            st = ST_ENC;
        end else if (n_long) begin
            st = ST_LONG;
        end else if (!n_nflags[0]) begin
            st = ST_NOTNUM;
        end else if (n_nflags[1] || (!n_neg && (n_mag > INT_MAX))) begin
            st = ST_RANGE;
        end else if (match) begin
            st = ST_OK;
        end else begin
            st = ST_MISMATCH;
        end

        cnt_wide = 64'(n_cnt);
        if (st == ST_NULL) begin
            len_out = '0;
        end else if (cnt_wide > LEN_SAT) begin
            len_out = '1;
        end else begin
            len_out = cnt_wide[LEN_W-1:0];
        end

        if (last) begin
            n_phase     = PH_TYPE;
            n_kind      = KIND_BULK;
            n_pos       = '0;
            n_null      = '0;
            n_held_byte = '0;
            n_held_vc   = '0;
            n_frame_bad = 1'b0;
            n_nstage    = NS_SKIP;
            n_neg       = 1'b0;
            n_mag       = '0;
            n_nflags    = '0;
            n_cnt       = '0;
            n_long      = 1'b0;
            n_colon     = '0;
        end
    end

    assign o_res_valid = i_go && (last || emit);

    always_comb begin
        if (last) begin
            o_res = '{out_byte: 8'd0, is_payload: 1'b0, status: st, text_length: len_out};
        end else begin
            o_res = '{out_byte: r_held_byte, is_payload: 1'b1, status: ST_OK,
                      text_length: '0};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TYPE;
            r_kind      <= KIND_BULK;
            r_pos       <= '0;
            r_null      <= '0;
            r_held_byte <= '0;
            r_held_vc   <= '0;
            r_frame_bad <= 1'b0;
            r_nstage    <= NS_SKIP;
            r_neg       <= 1'b0;
            r_mag       <= '0;
            r_nflags    <= '0;
            r_cnt       <= '0;
            r_long      <= 1'b0;
            r_colon     <= '0;
        end else if (i_go) begin
            r_phase     <= n_phase;
            r_kind      <= n_kind;
            r_pos       <= n_pos;
            r_null      <= n_null;
            r_held_byte <= n_held_byte;
            r_held_vc   <= n_held_vc;
            r_frame_bad <= n_frame_bad;
            r_nstage    <= n_nstage;
            r_neg       <= n_neg;
            r_mag       <= n_mag;
            r_nflags    <= n_nflags;
            r_cnt       <= n_cnt;
            r_long      <= n_long;
            r_colon     <= n_colon;
        end
    end

endmodule

/* rtl/rps_out_stage.sv */
// ============================================================================
// rps_out_stage
// Result register: holds one result beat until the consumer takes it.
// ============================================================================
module rps_out_stage (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_load,
    input  rps_pkg::t_result i_res,
    input  logic             i_stall,
    output logic             o_free,
    output logic             o_valid,
    output rps_pkg::t_result o_res
);
    import rps_pkg::*;

    logic    r_valid;
    t_result r_res;

    assign o_free  = !r_valid || !i_stall;
    assign o_valid = r_valid;
    assign o_res   = r_res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

endmodule

/* rtl/resp_length_prefixed_string_parser.sv */
// ============================================================================
// resp_length_prefixed_string_parser
// Checks length-prefixed string messages one byte beat at a time, streams
// payload bytes one beat late and closes each message with a status beat.
// ============================================================================
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+--------------------------------
//   input   | in        | i_valid / o_stall  | data_byte, last_byte, kind
//   result  | out       | o_valid / i_stall  | out_byte, is_payload, status,
//           |           |                    | text_length
//
// One byte beat per cycle while i_stall is low; path: input register, then
// parse logic into the result register.
// A byte that produces no result still waits for a free result register.
// Reset is synchronous, active low; no clearing pass.
// o_stall rises only while a byte sits in the input register and the result
// register is held by i_stall.
module resp_length_prefixed_string_parser (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    input  logic [1:0]  i_kind,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [7:0]  o_out_byte,
    output logic        o_is_payload,
    output logic [2:0]  o_status,
    output logic [15:0] o_text_length
);
    import rps_pkg::*;

    logic    item_valid;
    t_item   item;
    logic    out_free;
    logic    go;
    logic    res_valid;
    t_result res;
    t_result res_q;

    assign go = item_valid && out_free;

    rps_in_stage u_in (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_data_byte  (i_data_byte),
        .i_last_byte  (i_last_byte),
        .i_kind       (i_kind),
        .o_stall      (o_stall),
        .i_take       (go),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    rps_parse u_parse (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_go        (go),
        .i_item      (item),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    rps_out_stage u_out (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_valid),
        .i_res   (res),
        .i_stall (i_stall),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_res   (res_q)
    );

    assign o_out_byte    = res_q.out_byte;
    assign o_is_payload  = res_q.is_payload;
    assign o_status      = res_q.status;
    assign o_text_length = res_q.text_length;

endmodule

/* rtl/rps_chk.sv */
// ============================================================================
// rps_chk
// Port-level checker for the length-prefixed string parser, bound to the top.
// ============================================================================
module rps_chk (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [7:0]  o_out_byte,
    input logic        o_is_payload,
    input logic [2:0]  o_status,
    input logic [15:0] o_text_length
);
    import rps_pkg::*;

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("outputs not idle after reset");

    a_payload_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_is_payload |-> o_status == ST_OK && o_text_length == 16'd0)
        else $error("payload beat carries status fields");

    a_status_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_payload |-> o_out_byte == 8'd0 && o_status <= ST_LONG)
        else $error("bad status beat");

    a_null_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_is_payload && o_status == ST_NULL |-> o_text_length == 16'd0)
        else $error("null message with nonzero length");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_byte) && $stable(o_is_payload)
            && $stable(o_status) && $stable(o_text_length))
        else $error("stalled result beat changed");

endmodule

bind resp_length_prefixed_string_parser rps_chk u_rps_chk (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_stall       (o_stall),
    .o_valid       (o_valid),
    .i_stall       (i_stall),
    .o_out_byte    (o_out_byte),
    .o_is_payload  (o_is_payload),
    .o_status      (o_status),
    .o_text_length (o_text_length)
);
